/* rtl/core/v3fxalu_pkg.sv */
// Shared operation and status codes for the vector ALU.
`timescale 1ns / 1ps
`default_nettype none

package v3fxalu_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DIV   = 3'd3,
    OP_CROSS = 3'd4,
    OP_DOT   = 3'd5,
    OP_LEN   = 3'd6,
    OP_NORM  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/v3fxalu_ifs.sv */
// Valid/ready channel interfaces for operand and result transfers.
`timescale 1ns / 1ps
`default_nettype none

interface v3fxalu_in_if #(
  parameter int COMP_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   action;
  logic signed [COMP_WIDTH-1:0] ax;
  logic signed [COMP_WIDTH-1:0] ay;
  logic signed [COMP_WIDTH-1:0] az;
  logic signed [COMP_WIDTH-1:0] bx;
  logic signed [COMP_WIDTH-1:0] by;
  logic signed [COMP_WIDTH-1:0] bz;
  logic signed [COMP_WIDTH-1:0] factor;

  modport source (
    output valid, action, ax, ay, az, bx, by, bz, factor,
    input  ready
  );
  modport sink (
    input  valid, action, ax, ay, az, bx, by, bz, factor,
    output ready
  );
endinterface

interface v3fxalu_out_if #(
  parameter int COMP_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] rx;
  logic signed [COMP_WIDTH-1:0] ry;
  logic signed [COMP_WIDTH-1:0] rz;
  logic signed [COMP_WIDTH-1:0] scalar_out;
  logic [1:0]                   status;

  modport source (
    output valid, rx, ry, rz, scalar_out, status,
    input  ready
  );
  modport sink (
    input  valid, rx, ry, rz, scalar_out, status,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/vec3_fixed_point_alu.sv */
// Top level of the three-component fixed-point vector ALU.
`timescale 1ns / 1ps
`default_nettype none

// Stateless vector ALU on signed fixed point (COMP_WIDTH bits, FRAC_BITS
// fraction bits): add, sub, scale, divide, cross, dot, length, normalize.
// One item enters per cycle while in_ch.ready is high; the one-bit-per-stage
// square root (COMP_WIDTH stages) is followed by the one-bit-per-stage divider
// (COMP_WIDTH+FRAC_BITS stages). The whole pipeline holds while a finished
// result waits in the output register; in_ch.ready is low only then.
// Results saturate (status 1); divide by a zero factor returns zeros with
// status 2; normalize of a zero vector returns zeros with status 0.
module vec3_fixed_point_alu #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  v3fxalu_in_if.sink        in_ch,
  v3fxalu_out_if.source     out_ch
);

  localparam int W     = COMP_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int NUM_W = W + F;
  localparam int NSTG  = 3 + W + NUM_W;

  typedef struct packed {
    v3fxalu_pkg::op_t   op;
    logic [2:0]         aneg;
    logic [2:0][W-1:0]  aabs;
    logic [W-1:0]       fabs;
    logic               fneg;
    logic               fzero;
  } in_side_t;

  typedef struct packed {
    in_side_t           s;
    logic [2:0][W-1:0]  evec;
    logic [W-1:0]       escal;
    logic               esat;
  } sq_side_t;

  typedef struct packed {
    v3fxalu_pkg::op_t   op;
    logic [2:0]         neg;
    logic               dzero;
    logic [2:0][W-1:0]  evec;
    logic [W-1:0]       escal;
    logic               esat;
  } dv_side_t;

  logic                   en;
  logic [NSTG-1:0]        valid_r;
  logic                   out_valid_r;
  logic signed [W-1:0]    av [3];
  logic signed [W-1:0]    bv [3];
  in_side_t               side_in;
  in_side_t               side1_r, side2_r, side3_r;
  sq_side_t               sq_side_r [W];
  dv_side_t               dv_in;
  dv_side_t               dv_side_r [NUM_W];
  logic [2:0][W-1:0]      lane_vec;
  logic [2:0]             lane_sat;
  logic [2:0][2*W-1:0]    lane_term;
  logic [2:0][W-1:0]      evec;
  logic [W-1:0]           escal;
  logic                   esat;
  logic [2*W-1:0]         rad;
  logic [W-1:0]           root;
  logic [W-1:0]           dv_den;
  logic [NUM_W-1:0]       quo [3];
  logic [2:0][W-1:0]      dvec;
  logic [2:0]             dsat;
  logic [2:0][W-1:0]      fin_vec;
  logic [W-1:0]           fin_scal;
  v3fxalu_pkg::status_t   fin_st;
  logic [W-1:0]           rx_r, ry_r, rz_r, scal_r;
  v3fxalu_pkg::status_t   st_r;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;

  assign av[0] = in_ch.ax;
  assign av[1] = in_ch.ay;
  assign av[2] = in_ch.az;
  assign bv[0] = in_ch.bx;
  assign bv[1] = in_ch.by;
  assign bv[2] = in_ch.bz;

  always_comb begin
    side_in.op    = v3fxalu_pkg::op_t'(in_ch.action);
    for (int i = 0; i < 3; i++) begin
      side_in.aneg[i] = av[i][W-1];
      side_in.aabs[i] = av[i][W-1] ? (~av[i] + 1'b1) : av[i];
    end
    side_in.fneg  = in_ch.factor[W-1];
    side_in.fabs  = in_ch.factor[W-1] ? (~in_ch.factor + 1'b1) : in_ch.factor;
    side_in.fzero = (in_ch.factor == '0);
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3fxalu_lane #(.W(W), .F(F)) u_lane (
      .clk  (clk),
      .en   (en),
      .op   (side_in.op),
      .a_i  (av[i]),
      .b_i  (bv[i]),
      .a_j  (av[(i+1)%3]),
      .b_j  (bv[(i+1)%3]),
      .a_k  (av[(i+2)%3]),
      .b_k  (bv[(i+2)%3]),
      .f    (in_ch.factor),
      .vec  (lane_vec[i]),
      .vsat (lane_sat[i]),
      .term (lane_term[i])
    );
  end

  v3fxalu_merge #(.W(W), .F(F)) u_merge (
    .clk   (clk),
    .en    (en),
    .op    (side2_r.op),
    .vec   (lane_vec),
    .vsat  (lane_sat),
    .term  (lane_term),
    .evec  (evec),
    .escal (escal),
    .esat  (esat),
    .rad   (rad)
  );

  v3fxalu_sqrt #(.OUT_W(W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r         <= side_in;
      side2_r         <= side1_r;
      side3_r         <= side2_r;
      sq_side_r[0]    <= '{s: side3_r, evec: evec, escal: escal, esat: esat};
      for (int k = 1; k < W; k++) begin
        sq_side_r[k] <= sq_side_r[k-1];
      end
      dv_side_r[0]    <= dv_in;
      for (int k = 1; k < NUM_W; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  always_comb begin
    dv_in.op    = sq_side_r[W-1].s.op;
    dv_in.evec  = sq_side_r[W-1].evec;
    dv_in.escal = sq_side_r[W-1].escal;
    dv_in.esat  = sq_side_r[W-1].esat;
    if (sq_side_r[W-1].s.op == v3fxalu_pkg::OP_DIV) begin
      dv_den      = sq_side_r[W-1].s.fabs;
      dv_in.dzero = sq_side_r[W-1].s.fzero;
      dv_in.neg   = sq_side_r[W-1].s.aneg ^ {3{sq_side_r[W-1].s.fneg}};
    end else begin
      dv_den      = root;
      dv_in.dzero = (root == '0);
      dv_in.neg   = sq_side_r[W-1].s.aneg;
    end
    if (sq_side_r[W-1].s.op == v3fxalu_pkg::OP_LEN) begin
      dv_in.escal = root[W-1] ? {1'b0, {(W-1){1'b1}}} : root;
      dv_in.esat  = root[W-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3fxalu_div #(.DEN_W(W), .NUM_W(NUM_W)) u_div (
      .clk (clk),
      .en  (en),
      .num ({sq_side_r[W-1].s.aabs[i], {F{1'b0}}}),
      .den (dv_den),
      .quo (quo[i])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_side_r[NUM_W-1].neg[i]) begin
        dsat[i] = (|quo[i][NUM_W-1:W]) || (quo[i][W-1] && (|quo[i][W-2:0]));
        dvec[i] = dsat[i] ? {1'b1, {(W-1){1'b0}}} : (~quo[i][W-1:0] + 1'b1);
      end else begin
        dsat[i] = |quo[i][NUM_W-1:W-1];
        dvec[i] = dsat[i] ? {1'b0, {(W-1){1'b1}}} : quo[i][W-1:0];
      end
    end
    fin_scal = dv_side_r[NUM_W-1].escal;
    fin_st   = dv_side_r[NUM_W-1].esat ? v3fxalu_pkg::ST_SAT : v3fxalu_pkg::ST_OK;
    fin_vec  = dv_side_r[NUM_W-1].evec;
    if (dv_side_r[NUM_W-1].op == v3fxalu_pkg::OP_DIV ||
        dv_side_r[NUM_W-1].op == v3fxalu_pkg::OP_NORM) begin
      fin_scal = '0;
      if (dv_side_r[NUM_W-1].dzero) begin
        fin_vec = '0;
        fin_st  = (dv_side_r[NUM_W-1].op == v3fxalu_pkg::OP_DIV) ?
                  v3fxalu_pkg::ST_DIV0 : v3fxalu_pkg::ST_OK;
      end else begin
        fin_vec = dvec;
        fin_st  = (|dsat) ? v3fxalu_pkg::ST_SAT : v3fxalu_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      valid_r     <= {valid_r[NSTG-2:0], in_ch.valid};
      out_valid_r <= valid_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r   <= fin_vec[0];
      ry_r   <= fin_vec[1];
      rz_r   <= fin_vec[2];
      scal_r <= fin_scal;
      st_r   <= fin_st;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.rx         = rx_r;
  assign out_ch.ry         = ry_r;
  assign out_ch.rz         = rz_r;
  assign out_ch.scalar_out = scal_r;
  assign out_ch.status     = st_r;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(valid_r))
    else $error("pipeline valid bits moved during a stall");

  a_rise_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(valid_r[NSTG-1]))
    else $error("result appeared without an item at the last stage");

  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && st_r == v3fxalu_pkg::ST_DIV0) |->
      (rx_r == '0 && ry_r == '0 && rz_r == '0 && scal_r == '0))
    else $error("divide-by-zero result not zeroed");

  a_scalar_xor_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && scal_r != '0) |-> (rx_r == '0 && ry_r == '0 && rz_r == '0))
    else $error("scalar and vector results both nonzero");
`endif

endmodule

`default_nettype wire

/* rtl/core/v3fxalu_lane.sv */
// One component lane: two multipliers, add/sub, floor shift and saturation.
`timescale 1ns / 1ps
`default_nettype none

module v3fxalu_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire v3fxalu_pkg::op_t      op,
  input  wire logic signed [W-1:0]   a_i,
  input  wire logic signed [W-1:0]   b_i,
  input  wire logic signed [W-1:0]   a_j,
  input  wire logic signed [W-1:0]   b_j,
  input  wire logic signed [W-1:0]   a_k,
  input  wire logic signed [W-1:0]   b_k,
  input  wire logic signed [W-1:0]   f,
  output logic [W-1:0]               vec,
  output logic                       vsat,
  output logic [2*W-1:0]             term
);

  localparam int VW = 2*W + 1;

  logic signed [W-1:0]   x0, y0;
  logic signed [2*W-1:0] m0_r, m1_r;
  logic signed [W:0]     as_r;
  v3fxalu_pkg::op_t      op1_r;
  logic signed [VW-1:0]  d, sh, val;
  logic                  ovp, ovn, is_vec;
  logic [W-1:0]          satv;
  logic [W-1:0]          vec_r;
  logic                  vsat_r;
  logic [2*W-1:0]        term_r;

  always_comb begin
    x0 = (op == v3fxalu_pkg::OP_CROSS) ? a_j : a_i;
    case (op)
      v3fxalu_pkg::OP_SCALE: y0 = f;
      v3fxalu_pkg::OP_CROSS: y0 = b_k;
      v3fxalu_pkg::OP_LEN,
      v3fxalu_pkg::OP_NORM:  y0 = a_i;
      default:               y0 = b_i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r  <= x0 * y0;
      m1_r  <= a_k * b_j;
      as_r  <= (op == v3fxalu_pkg::OP_SUB) ?
               ({a_i[W-1], a_i} - {b_i[W-1], b_i}) : ({a_i[W-1], a_i} + {b_i[W-1], b_i});
      op1_r <= op;
    end
  end

  always_comb begin
    if (op1_r == v3fxalu_pkg::OP_CROSS) begin
      d = {m0_r[2*W-1], m0_r} - {m1_r[2*W-1], m1_r};
    end else begin
      d = {m0_r[2*W-1], m0_r};
    end
    sh = d >>> F;
    if (op1_r == v3fxalu_pkg::OP_ADD || op1_r == v3fxalu_pkg::OP_SUB) begin
      val = {{(VW-W-1){as_r[W]}}, as_r};
    end else begin
      val = sh;
    end
    ovp  = !val[VW-1] && (|val[VW-2:W-1]);
    ovn  = val[VW-1] && !(&val[VW-2:W-1]);
    if (ovp) begin
      satv = {1'b0, {(W-1){1'b1}}};
    end else if (ovn) begin
      satv = {1'b1, {(W-1){1'b0}}};
    end else begin
      satv = val[W-1:0];
    end
    is_vec = op1_r inside {v3fxalu_pkg::OP_ADD, v3fxalu_pkg::OP_SUB,
                           v3fxalu_pkg::OP_SCALE, v3fxalu_pkg::OP_CROSS};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r  <= is_vec ? satv : '0;
      vsat_r <= is_vec && (ovp || ovn);
      term_r <= m0_r;
    end
  end

  assign vec  = vec_r;
  assign vsat = vsat_r;
  assign term = term_r;

endmodule

`default_nettype wire

/* rtl/core/v3fxalu_merge.sv */
// Merge stage: sums lane products for dot and length, packs early results.
`timescale 1ns / 1ps
`default_nettype none

module v3fxalu_merge #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire v3fxalu_pkg::op_t      op,
  input  wire logic [2:0][W-1:0]     vec,
  input  wire logic [2:0]            vsat,
  input  wire logic [2:0][2*W-1:0]   term,
  output logic [2:0][W-1:0]          evec,
  output logic [W-1:0]               escal,
  output logic                       esat,
  output logic [2*W-1:0]             rad
);

  localparam int SW = 2*W + 2;

  logic signed [SW-1:0] sum, sh;
  logic                 ovp, ovn, is_dot;
  logic [W-1:0]         satv;
  logic [2:0][W-1:0]    evec_r;
  logic [W-1:0]         escal_r;
  logic                 esat_r;
  logic [2*W-1:0]       rad_r;

  always_comb begin
    sum = $signed({{2{term[0][2*W-1]}}, term[0]}) + $signed({{2{term[1][2*W-1]}}, term[1]})
        + $signed({{2{term[2][2*W-1]}}, term[2]});
    sh  = sum >>> F;
    ovp = !sh[SW-1] && (|sh[SW-2:W-1]);
    ovn = sh[SW-1] && !(&sh[SW-2:W-1]);
    if (ovp) begin
      satv = {1'b0, {(W-1){1'b1}}};
    end else if (ovn) begin
      satv = {1'b1, {(W-1){1'b0}}};
    end else begin
      satv = sh[W-1:0];
    end
    is_dot = (op == v3fxalu_pkg::OP_DOT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      evec_r  <= vec;
      escal_r <= is_dot ? satv : '0;
      esat_r  <= (|vsat) || (is_dot && (ovp || ovn));
      rad_r   <= sum[2*W-1:0];
    end
  end

  assign evec  = evec_r;
  assign escal = escal_r;
  assign esat  = esat_r;
  assign rad   = rad_r;

endmodule

`default_nettype wire

/* rtl/core/v3fxalu_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module v3fxalu_sqrt #(
  parameter int OUT_W = 32
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [2*OUT_W-1:0]   rad,
  output logic [OUT_W-1:0]          root
);

  localparam int IN_W = 2*OUT_W;

  logic [IN_W-1:0]  rad_r  [OUT_W];
  logic [OUT_W+1:0] rem_r  [OUT_W];
  logic [OUT_W-1:0] root_r [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic [IN_W-1:0]  rad_i;
    logic [OUT_W+1:0] rem_i, rem_sh, trial;
    logic [OUT_W-1:0] root_i;

    if (k == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
    end

    assign rem_sh = {rem_i[OUT_W-1:0], rad_i[IN_W-1 -: 2]};
    assign trial  = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k] <= rad_i << 2;
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_i[OUT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_i[OUT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[OUT_W-1];

endmodule

`default_nettype wire

/* rtl/core/v3fxalu_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module v3fxalu_div #(
  parameter int DEN_W = 32,
  parameter int NUM_W = 48
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [DEN_W-1:0]   den,
  output logic [NUM_W-1:0]        quo
);

  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] num_i;
    logic [DEN_W-1:0] rem_i, den_i;
    logic [DEN_W:0]   rem_sh, dif;
    logic             ge;

    if (k == 0) begin : g_first
      assign num_i = num;
      assign rem_i = '0;
      assign den_i = den;
    end else begin : g_next
      assign num_i = num_r[k-1];
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
    end

    assign rem_sh = {rem_i, num_i[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_i};
    assign dif    = rem_sh - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= {num_i[NUM_W-2:0], ge};
        rem_r[k] <= ge ? dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        den_r[k] <= den_i;
      end
    end
  end

  assign quo = num_r[NUM_W-1];

endmodule

`default_nettype wire

/* sim/vec3_fixed_point_alu_tb.sv */
// Self-checking testbench for the fixed-point vector ALU: directed and random transfers.
`timescale 1ns / 1ps

module vec3_fixed_point_alu_tb;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int LATENCY = 2 * W + FB + 4;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM = 930;
  localparam logic signed [W-1:0] MAXV = 32'sh7fffffff;
  localparam logic signed [W-1:0] MINV = 32'sh80000000;

  typedef struct packed {
    v3fxalu_pkg::op_t action;
    logic signed [W-1:0] ax, ay, az, bx, by, bz, factor;
  } operands_t;

  typedef struct packed {
    logic signed [W-1:0] rx, ry, rz, scalar_out;
    v3fxalu_pkg::status_t status;
  } alu_result_t;

  typedef struct packed {
    operands_t ops;
    logic has_exp;
    alu_result_t exp;
  } vector_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  v3fxalu_in_if #(.COMP_WIDTH(W)) in_ch ();
  v3fxalu_out_if #(.COMP_WIDTH(W)) out_ch ();

  vec3_fixed_point_alu #(.COMP_WIDTH(W), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  alu_result_t expected_results[$];
  int errors = 0;
  bit send_done = 0;
  bit drain_hold = 0;
  int long_hold = 0;
  int idle_cycles = 0;

  function automatic logic signed [W-1:0] clamp(input logic signed [127:0] v, inout bit sat);
    if (v > 128'(signed'(MAXV))) begin
      sat = 1;
      return MAXV;
    end
    if (v < 128'(signed'(MINV))) begin
      sat = 1;
      return MINV;
    end
    return v[W-1:0];
  endfunction

  function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                   input logic signed [127:0] d);
    logic [127:0] q;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [127:0] isqrt(input logic [127:0] s);
    logic [127:0] r, c;
    r = 0;
    for (int b = 49; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic alu_result_t compute_vec3(input operands_t o);
    alu_result_t r;
    logic signed [127:0] a[3], b[3], f, v[3], len;
    bit sat;
    sat = 0;
    r = '0;
    a[0] = o.ax; a[1] = o.ay; a[2] = o.az;
    b[0] = o.bx; b[1] = o.by; b[2] = o.bz;
    f = o.factor;
    v[0] = 0; v[1] = 0; v[2] = 0;
    case (o.action)
      v3fxalu_pkg::OP_ADD: for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
      v3fxalu_pkg::OP_SUB: for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
      v3fxalu_pkg::OP_SCALE: for (int i = 0; i < 3; i++) v[i] = (a[i] * f) >>> FB;
      v3fxalu_pkg::OP_DIV:
        if (f != 0) for (int i = 0; i < 3; i++) v[i] = div_trunc(a[i] <<< FB, f);
      v3fxalu_pkg::OP_CROSS: begin
        v[0] = (a[1] * b[2] - a[2] * b[1]) >>> FB;
        v[1] = (a[2] * b[0] - a[0] * b[2]) >>> FB;
        v[2] = (a[0] * b[1] - a[1] * b[0]) >>> FB;
      end
      v3fxalu_pkg::OP_DOT:
        r.scalar_out = clamp((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FB, sat);
      default: begin
        len = $signed(isqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]));
        if (o.action == v3fxalu_pkg::OP_LEN) r.scalar_out = clamp(len, sat);
        else if (len != 0) for (int i = 0; i < 3; i++) v[i] = div_trunc(a[i] <<< FB, len);
      end
    endcase
    if (!(o.action inside {v3fxalu_pkg::OP_DOT, v3fxalu_pkg::OP_LEN})) begin
      r.rx = clamp(v[0], sat);
      r.ry = clamp(v[1], sat);
      r.rz = clamp(v[2], sat);
    end
    if (o.action == v3fxalu_pkg::OP_DIV && f == 0) r.status = v3fxalu_pkg::ST_DIV0;
    else r.status = sat ? v3fxalu_pkg::ST_SAT : v3fxalu_pkg::ST_OK;
    return r;
  endfunction

  function automatic logic signed [W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return MAXV;
      1: return MINV;
      2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      3: return 0;
      default: return $urandom();
    endcase
  endfunction

  function automatic operands_t rand_ops();
    operands_t o;
    o.action = v3fxalu_pkg::op_t'($urandom_range(0, 7));
    o.ax = rand_comp(); o.ay = rand_comp(); o.az = rand_comp();
    o.bx = rand_comp(); o.by = rand_comp(); o.bz = rand_comp();
    o.factor = ($urandom_range(0, 15) == 0) ? '0 : rand_comp();
    return o;
  endfunction

  function automatic alu_result_t mk_res(input logic signed [W-1:0] x, y, z, s,
                                         input v3fxalu_pkg::status_t st);
    alu_result_t r;
    r.rx = x; r.ry = y; r.rz = z; r.scalar_out = s; r.status = st;
    return r;
  endfunction

  vector_row_t directed_rows[$];

  task automatic add_row(input v3fxalu_pkg::op_t op,
                         input logic signed [W-1:0] ax, ay, az, bx, by, bz, f,
                         input bit has, input alu_result_t e);
    vector_row_t row;
    row.ops.action = op;
    row.ops.ax = ax; row.ops.ay = ay; row.ops.az = az;
    row.ops.bx = bx; row.ops.by = by; row.ops.bz = bz; row.ops.factor = f;
    row.has_exp = has;
    row.exp = e;
    directed_rows.push_back(row);
  endtask

  task automatic send_item(input operands_t o, input bit has, input alu_result_t e);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= o.action;
    in_ch.ax <= o.ax; in_ch.ay <= o.ay; in_ch.az <= o.az;
    in_ch.bx <= o.bx; in_ch.by <= o.by; in_ch.bz <= o.bz;
    in_ch.factor <= o.factor;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(has ? e : compute_vec3(o));
    @(negedge clk);
  endtask

  initial begin
    alu_result_t z;
    z = '0;
    in_ch.valid = 1'b0;
    in_ch.action = v3fxalu_pkg::OP_ADD;
    {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by, in_ch.bz, in_ch.factor} = '0;
    add_row(v3fxalu_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0, 1,
            mk_res(0, 0, 0, 0, v3fxalu_pkg::ST_OK));
    add_row(v3fxalu_pkg::OP_ADD, MAXV, MINV, 1, 1, -1, -1, 0, 1,
            mk_res(MAXV, MINV, 0, 0, v3fxalu_pkg::ST_SAT));
    add_row(v3fxalu_pkg::OP_SUB, MINV, MAXV, 5, 1, -1, 5, 0, 1,
            mk_res(MINV, MAXV, 0, 0, v3fxalu_pkg::ST_SAT));
    add_row(v3fxalu_pkg::OP_SCALE, 32'sh10000, -32'sh20000, MAXV, 0, 0, 0, 32'sh20000, 1,
            mk_res(32'sh20000, -32'sh40000, MAXV, 0, v3fxalu_pkg::ST_SAT));
    add_row(v3fxalu_pkg::OP_SCALE, MINV, MAXV, 3, 0, 0, 0, MINV, 0, z);
    add_row(v3fxalu_pkg::OP_DIV, 7, 8, 9, 0, 0, 0, 0, 1,
            mk_res(0, 0, 0, 0, v3fxalu_pkg::ST_DIV0));
    add_row(v3fxalu_pkg::OP_DIV, MAXV, MINV, 32'sh10000, 0, 0, 0, 1, 0, z);
    add_row(v3fxalu_pkg::OP_DIV, -32'sh30000, 5, MINV, 0, 0, 0, -32'sh20000, 0, z);
    add_row(v3fxalu_pkg::OP_CROSS, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 1,
            mk_res(0, 0, 32'sh10000, 0, v3fxalu_pkg::ST_OK));
    add_row(v3fxalu_pkg::OP_CROSS, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0, 0, z);
    add_row(v3fxalu_pkg::OP_DOT, 32'sh10000, 32'sh20000, 32'sh30000,
            32'sh10000, 32'sh10000, 32'sh10000, 0, 1,
            mk_res(0, 0, 0, 32'sh60000, v3fxalu_pkg::ST_OK));
    add_row(v3fxalu_pkg::OP_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 0, 0, z);
    add_row(v3fxalu_pkg::OP_LEN, 32'sh30000, 32'sh40000, 0, 0, 0, 0, 0, 1,
            mk_res(0, 0, 0, 32'sh50000, v3fxalu_pkg::ST_OK));
    add_row(v3fxalu_pkg::OP_LEN, MINV, MINV, MINV, 0, 0, 0, 0, 0, z);
    add_row(v3fxalu_pkg::OP_LEN, 0, 0, 0, 9, 9, 9, 9, 1,
            mk_res(0, 0, 0, 0, v3fxalu_pkg::ST_OK));
    add_row(v3fxalu_pkg::OP_NORM, 0, 0, 0, 1, 2, 3, 4, 1,
            mk_res(0, 0, 0, 0, v3fxalu_pkg::ST_OK));
    add_row(v3fxalu_pkg::OP_NORM, 32'sh30000, 0, 0, 0, 0, 0, 0, 1,
            mk_res(32'sh10000, 0, 0, 0, v3fxalu_pkg::ST_OK));
    add_row(v3fxalu_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0, z);
    add_row(v3fxalu_pkg::OP_NORM, MAXV, MINV, -1, 0, 0, 0, 0, 0, z);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].ops, directed_rows[i].has_exp, directed_rows[i].exp);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) long_hold = 300;
      if (n == 500) begin
        in_ch.valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(negedge clk);
      end
      send_item(rand_ops(), 0, z);
    end
    in_ch.valid <= 1'b0;
    send_done = 1;
  end

  // result side: random back-pressure plus one long hold
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (long_hold) @(negedge clk);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    alu_result_t got, exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = mk_res(out_ch.rx, out_ch.ry, out_ch.rz, out_ch.scalar_out,
                   v3fxalu_pkg::status_t'(out_ch.status));
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer rx=%h ry=%h rz=%h s=%h st=%0d", $time,
                 got.rx, got.ry, got.rz, got.scalar_out, got.status);
      end else begin
        exp = expected_results.pop_front();
        if (got.rx !== exp.rx) begin
          errors++;
          $display("%0t: rx exp %h got %h", $time, exp.rx, got.rx);
        end
        if (got.ry !== exp.ry) begin
          errors++;
          $display("%0t: ry exp %h got %h", $time, exp.ry, got.ry);
        end
        if (got.rz !== exp.rz) begin
          errors++;
          $display("%0t: rz exp %h got %h", $time, exp.rz, got.rz);
        end
        if (got.scalar_out !== exp.scalar_out) begin
          errors++;
          $display("%0t: scalar_out exp %h got %h", $time, exp.scalar_out, got.scalar_out);
        end
        if (got.status !== exp.status) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    wait (send_done);
    wait (expected_results.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/v3fxalu_pkg.sv
rtl/core/v3fxalu_ifs.sv
rtl/core/v3fxalu_lane.sv
rtl/core/v3fxalu_merge.sv
rtl/core/v3fxalu_sqrt.sv
rtl/core/v3fxalu_div.sv
rtl/core/vec3_fixed_point_alu.sv
sim/vec3_fixed_point_alu_tb.sv
